// ----- design/command_frame_parse_and_forward_core_macros.svh -----
// Assertion helpers for the command frame parser.
`ifndef COMMAND_FRAME_PARSE_AND_FORWARD_CORE_MACROS_SVH
`define COMMAND_FRAME_PARSE_AND_FORWARD_CORE_MACROS_SVH

// Hold a property at every clock edge outside reset.
`define CFPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Hold an implication at every clock edge outside reset.
`define CFPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/cfpf_pkg.sv -----
`default_nettype none
package cfpf_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] CAL_CHAN = 8'h55;
  localparam logic [7:0] MAX_LOCAL_CHAN = 8'd2;

  localparam logic [4:0] LEN_SLOPE = 5'd12;
  localparam logic [4:0] LEN_SINE  = 5'd16;
  localparam logic [4:0] LEN_PWM   = 5'd16;
  localparam logic [4:0] LEN_DC    = 5'd8;
  localparam logic [4:0] LEN_CAL   = 5'd6;
  localparam logic [4:0] LEN_NONE  = 5'd0;

  localparam logic [1:0] KIND_CAN  = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_CAL  = 2'd2;

  localparam logic [2:0] REG_BOARD_ID   = 3'd0;
  localparam logic [2:0] REG_CODE_SLOPE = 3'd1;
  localparam logic [2:0] REG_CODE_SINE  = 3'd2;
  localparam logic [2:0] REG_CODE_PWM   = 3'd3;
  localparam logic [2:0] REG_CODE_DC    = 3'd4;

  localparam logic [7:0] RST_BOARD_ID   = 8'd0;
  localparam logic [7:0] RST_CODE_SLOPE = 8'd0;
  localparam logic [7:0] RST_CODE_SINE  = 8'd1;
  localparam logic [7:0] RST_CODE_PWM   = 8'd2;
  localparam logic [7:0] RST_CODE_DC    = 8'd3;

  typedef enum logic [1:0] {
    MODE_CAN,
    MODE_WORD,
    MODE_CAL
  } mode_e;

  typedef struct packed {
    logic [7:0] board_id;
    logic [7:0] code_slope;
    logic [7:0] code_sine;
    logic [7:0] code_pwm;
    logic [7:0] code_dc;
  } cfg_t;

  typedef struct packed {
    logic [7:0] target;
    logic [7:0] channel;
    logic [7:0] wtype;
    logic [4:0] len;
    mode_e      mode;
    logic [2:0] ngrp;
  } frame_t;

  function automatic logic [7:0] cal_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h43;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4C;
      3'd4:    c = 8'h49;
      3'd5:    c = 8'h42;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/cfpf_ram.sv -----
`default_nettype none
module cfpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]          wdata_i,
  input  wire  [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- design/cfpf_cfg.sv -----
`default_nettype none
module cfpf_cfg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [4:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfpf_pkg::cfg_t       cfg_o
);

  cfpf_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        cfpf_pkg::REG_BOARD_ID:   cfg_d.board_id   = pwdata[7:0];
        cfpf_pkg::REG_CODE_SLOPE: cfg_d.code_slope = pwdata[7:0];
        cfpf_pkg::REG_CODE_SINE:  cfg_d.code_sine  = pwdata[7:0];
        cfpf_pkg::REG_CODE_PWM:   cfg_d.code_pwm   = pwdata[7:0];
        cfpf_pkg::REG_CODE_DC:    cfg_d.code_dc    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cfpf_pkg::REG_BOARD_ID:   prdata = {24'd0, cfg_q.board_id};
      cfpf_pkg::REG_CODE_SLOPE: prdata = {24'd0, cfg_q.code_slope};
      cfpf_pkg::REG_CODE_SINE:  prdata = {24'd0, cfg_q.code_sine};
      cfpf_pkg::REG_CODE_PWM:   prdata = {24'd0, cfg_q.code_pwm};
      cfpf_pkg::REG_CODE_DC:    prdata = {24'd0, cfg_q.code_dc};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.board_id   <= cfpf_pkg::RST_BOARD_ID;
      cfg_q.code_slope <= cfpf_pkg::RST_CODE_SLOPE;
      cfg_q.code_sine  <= cfpf_pkg::RST_CODE_SINE;
      cfg_q.code_pwm   <= cfpf_pkg::RST_CODE_PWM;
      cfg_q.code_dc    <= cfpf_pkg::RST_CODE_DC;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/cfpf_rx.sv -----
`default_nettype none
module cfpf_rx #(
  parameter int unsigned MAX_PAYLOAD = cfpf_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  cfpf_pkg::cfg_t                     cfg_i,
  input  wire                                accept_i,
  input  wire  [7:0]                         in_byte_i,
  output logic                               we_o,
  output logic [$clog2(MAX_PAYLOAD)-1:0]     waddr_o,
  output logic [7:0]                         wdata_o,
  output logic                               start_o,
  output cfpf_pkg::frame_t                   frame_o
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);

  localparam logic [2:0] ST_HUNT0 = 3'd0;
  localparam logic [2:0] ST_HUNT1 = 3'd1;
  localparam logic [2:0] ST_TGT   = 3'd2;
  localparam logic [2:0] ST_CHN   = 3'd3;
  localparam logic [2:0] ST_TYP   = 3'd4;
  localparam logic [2:0] ST_PAY   = 3'd5;

  logic [2:0]       st_q, st_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [4:0]       cnt_inc;
  logic [4:0]       type_len;
  logic [5:0]       can_sum;
  logic             start_d, start_q;
  cfpf_pkg::frame_t frame_q, frame_d;

  always_comb begin
    priority if (in_byte_i == cfg_i.code_slope) type_len = cfpf_pkg::LEN_SLOPE;
    else if (in_byte_i == cfg_i.code_sine)      type_len = cfpf_pkg::LEN_SINE;
    else if (in_byte_i == cfg_i.code_pwm)       type_len = cfpf_pkg::LEN_PWM;
    else if (in_byte_i == cfg_i.code_dc)        type_len = cfpf_pkg::LEN_DC;
    else if (in_byte_i == cfpf_pkg::CAL_CHAN)   type_len = cfpf_pkg::LEN_CAL;
    else                                        type_len = cfpf_pkg::LEN_NONE;
  end

  assign cnt_inc = cnt_q + 5'd1;
  assign can_sum = {1'b0, frame_q.len} + 6'd12;
  assign we_o    = accept_i && (st_q == ST_PAY);
  assign waddr_o = cnt_q[AW-1:0];
  assign wdata_o = in_byte_i;
  assign start_o = start_q;
  assign frame_o = frame_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    frame_d = frame_q;
    start_d = 1'b0;
    if (accept_i) begin
      unique case (st_q)
        ST_HUNT0: st_d = (in_byte_i == cfpf_pkg::HDR_BYTE) ? ST_HUNT1 : ST_HUNT0;
        ST_HUNT1: st_d = (in_byte_i == cfpf_pkg::HDR_BYTE) ? ST_TGT : ST_HUNT0;
        ST_TGT: begin
          frame_d.target = in_byte_i;
          st_d = ST_CHN;
        end
        ST_CHN: begin
          frame_d.channel = in_byte_i;
          st_d = ST_TYP;
        end
        ST_TYP: begin
          frame_d.wtype = in_byte_i;
          cnt_d = 5'd0;
          if (type_len == cfpf_pkg::LEN_NONE || 32'(type_len) > MAX_PAYLOAD) begin
            frame_d.len = cfpf_pkg::LEN_NONE;
            st_d = ST_HUNT0;
          end else begin
            frame_d.len = type_len;
            st_d = ST_PAY;
          end
        end
        ST_PAY: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= frame_q.len) begin
            st_d = ST_HUNT0;
            priority if (frame_q.target != cfg_i.board_id) begin
              frame_d.mode = cfpf_pkg::MODE_CAN;
              frame_d.ngrp = can_sum[5:3];
              start_d = 1'b1;
            end else if (frame_q.channel <= cfpf_pkg::MAX_LOCAL_CHAN) begin
              frame_d.mode = cfpf_pkg::MODE_WORD;
              frame_d.ngrp = frame_q.len[4:2];
              start_d = (frame_q.len != cfpf_pkg::LEN_CAL);
            end else if (frame_q.channel == cfpf_pkg::CAL_CHAN) begin
              frame_d.mode = cfpf_pkg::MODE_CAL;
              frame_d.ngrp = 3'd1;
              start_d = 1'b1;
            end else begin
              start_d = 1'b0;
            end
          end
        end
        default: st_d = ST_HUNT0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_HUNT0;
      cnt_q         <= 5'd0;
      start_q       <= 1'b0;
      frame_q.target  <= 8'd0;
      frame_q.channel <= 8'd0;
      frame_q.wtype   <= 8'd0;
      frame_q.len     <= 5'd0;
      frame_q.mode    <= cfpf_pkg::MODE_CAN;
      frame_q.ngrp    <= 3'd0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      frame_q <= frame_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/cfpf_emit.sv -----
`default_nettype none
`include "command_frame_parse_and_forward_core_macros.svh"
module cfpf_emit #(
  parameter int unsigned AW = 4
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  cfpf_pkg::frame_t       frame_i,
  output logic                   busy_o,
  output logic [AW-1:0]          raddr_o,
  input  wire  [7:0]             rdata_i,
  input  wire                    out_stall_i,
  output logic                   out_valid_o,
  output logic [1:0]             kind_o,
  output logic [7:0]             target_id_o,
  output logic [7:0]             chan_sel_o,
  output logic [7:0]             wave_type_o,
  output logic [1:0]             seq_index_o,
  output logic [63:0]            payload_o,
  output logic                   last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [4:0]  v_q, v_d;
  logic [1:0]  grp_q, grp_d;
  logic        match_q, match_d;
  logic [63:0] acc_q, acc_d;
  logic [4:0]  idx;
  logic [7:0]  cur_byte;
  logic        grp_end;
  logic        out_free;
  logic        load_out;
  logic        is_last;

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  target_q, chan_q, wtype_q;
  logic [1:0]  seq_q;
  logic [63:0] payload_q, payload_d;
  logic        last_q;

  assign idx      = v_q - 5'd5;
  assign raddr_o  = (frame_i.mode == cfpf_pkg::MODE_CAN) ? idx[AW-1:0] : v_q[AW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (st_q == ST_EMIT) && out_free;
  assign is_last  = ({1'b0, grp_q} + 3'd1) == frame_i.ngrp;
  assign busy_o   = (st_q != ST_IDLE);

  always_comb begin
    cur_byte = rdata_i;
    grp_end  = 1'b0;
    unique case (frame_i.mode)
      cfpf_pkg::MODE_CAN: begin
        if (v_q < 5'd5) begin
          unique case (v_q[2:0])
            3'd2:    cur_byte = frame_i.target;
            3'd3:    cur_byte = frame_i.channel;
            3'd4:    cur_byte = frame_i.wtype;
            default: cur_byte = cfpf_pkg::HDR_BYTE;
          endcase
        end else if (idx >= frame_i.len) begin
          cur_byte = 8'd0;
        end
        grp_end = (v_q[2:0] == 3'd7);
      end
      cfpf_pkg::MODE_WORD: grp_end = (v_q[1:0] == 2'd3);
      cfpf_pkg::MODE_CAL:  grp_end = (v_q == 5'd5);
      default:             grp_end = 1'b1;
    endcase
  end

  always_comb begin
    unique case (frame_i.mode)
      cfpf_pkg::MODE_CAN:  payload_d = acc_q;
      cfpf_pkg::MODE_WORD: payload_d = {32'd0, acc_q[31:0]};
      default:             payload_d = 64'd0;
    endcase
  end

  always_comb begin
    st_d    = st_q;
    v_d     = v_q;
    grp_d   = grp_q;
    match_d = match_q;
    acc_d   = acc_q;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          v_d     = 5'd0;
          grp_d   = 2'd0;
          match_d = 1'b1;
          st_d    = ST_FETCH;
        end
      end
      ST_FETCH: st_d = ST_SHIFT;
      ST_SHIFT: begin
        acc_d   = {acc_q[55:0], cur_byte};
        match_d = match_q && (rdata_i == cfpf_pkg::cal_char(v_q[2:0]));
        v_d     = v_q + 5'd1;
        if (!grp_end) begin
          st_d = ST_FETCH;
        end else if (frame_i.mode == cfpf_pkg::MODE_CAL && !match_d) begin
          st_d = ST_IDLE;
        end else begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            st_d = ST_IDLE;
          end else begin
            grp_d = grp_q + 2'd1;
            st_d  = ST_FETCH;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      v_q         <= 5'd0;
      grp_q       <= 2'd0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      v_q     <= v_d;
      grp_q   <= grp_d;
      match_q <= match_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load_out) begin
      unique case (frame_i.mode)
        cfpf_pkg::MODE_CAN:  kind_q <= cfpf_pkg::KIND_CAN;
        cfpf_pkg::MODE_WORD: kind_q <= cfpf_pkg::KIND_WORD;
        default:             kind_q <= cfpf_pkg::KIND_CAL;
      endcase
      target_q  <= frame_i.target;
      chan_q    <= frame_i.channel;
      wtype_q   <= frame_i.wtype;
      seq_q     <= grp_q;
      payload_q <= payload_d;
      last_q    <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign target_id_o = target_q;
  assign chan_sel_o  = chan_q;
  assign wave_type_o = wtype_q;
  assign seq_index_o = seq_q;
  assign payload_o   = payload_q;
  assign last_o      = last_q;

  `CFPF_ASSERT_IMP(a_start_idle, start_i, st_q == ST_IDLE, "frame start while sequencer busy")
  `CFPF_ASSERT_IMP(a_grp_range, load_out, {1'b0, grp_q} < frame_i.ngrp, "result past group count")
  `CFPF_ASSERT_IMP(a_cal_range, (st_q == ST_FETCH || st_q == ST_SHIFT) && frame_i.mode == cfpf_pkg::MODE_CAL, v_q <= 5'd5, "calibration read past tag")
  `CFPF_ASSERT_IMP(a_word_range, (st_q == ST_FETCH || st_q == ST_SHIFT) && frame_i.mode == cfpf_pkg::MODE_WORD, v_q < frame_i.len, "word read past payload")

endmodule
`default_nettype wire

// ----- design/command_frame_parse_and_forward_core.sv -----
// Command frame parser and forwarder.
// Input channel: one received byte per transaction (in_valid_i / in_stall_o,
// in_byte_i). Header, target, channel and type bytes are parsed in turn;
// payload bytes are buffered in a small RAM.
// Output channel: one result per transaction (out_valid_o / out_stall_i):
// forwarded CAN frames, big-endian payload words or a calibration request.
// After the last payload byte of a frame, a sequencer reads the buffer one
// byte at a time through a single registered RAM port, fetching and then
// shifting each byte, and assembles each result in a shift register from
// eight bytes for a CAN frame, four for a payload word or six for the
// calibration check, then loads the output register. A frame gives up to
// four results. in_stall_o stays high while results are assembled; header
// bytes of the next frame are taken as soon as the last result sits in the
// output register. A stalled receiver holds the output register and the
// sequencer. Configuration registers sit behind the APB port; they are to
// be written only while idle, which the block itself does not enforce.
// Reset returns to header hunt and restores register defaults; the payload
// buffer needs no clearing.
`default_nettype none
module command_frame_parse_and_forward_core #(
  parameter int unsigned MAX_PAYLOAD = cfpf_pkg::MAX_PAYLOAD_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire  [7:0]   in_byte_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic [1:0]   kind_o,
  output logic [7:0]   target_id_o,
  output logic [7:0]   chan_sel_o,
  output logic [7:0]   wave_type_o,
  output logic [1:0]   seq_index_o,
  output logic [63:0]  payload_o,
  output logic         last_o
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);

  cfpf_pkg::cfg_t   cfg;
  cfpf_pkg::frame_t frame;
  logic             accept;
  logic             start;
  logic             busy;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [7:0]       wdata;
  logic [7:0]       rdata;

  assign in_stall_o = busy || start;
  assign accept     = in_valid_i && !in_stall_o;

  cfpf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cfpf_rx #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .start_o   (start),
    .frame_o   (frame)
  );

  cfpf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cfpf_emit #(
    .AW (AW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .frame_i     (frame),
    .busy_o      (busy),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .target_id_o (target_id_o),
    .chan_sel_o  (chan_sel_o),
    .wave_type_o (wave_type_o),
    .seq_index_o (seq_index_o),
    .payload_o   (payload_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire
